/* src/sme_pkg.sv */
// sme_pkg: shared types and constants of the stack machine executor
// opcodes, error codes, field widths and the divider request bundle
// no dependencies
`default_nettype none

package sme_pkg;

    localparam int WORD_W     = 32;
    localparam int IMM_W      = 24;
    localparam int OPC_W      = 8;
    localparam int NPC_W      = 16;
    localparam int ERR_W      = 4;
    localparam int CODE_W     = 16;
    localparam int GCNT_W     = 9;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_SIZE    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GLOBAL_COUNT = 1'b1;

    // opcodes
    localparam logic [OPC_W-1:0] OP_HALT  = 8'd0;
    localparam logic [OPC_W-1:0] OP_PUSHC = 8'd1;
    localparam logic [OPC_W-1:0] OP_ADD   = 8'd2;
    localparam logic [OPC_W-1:0] OP_SUB   = 8'd3;
    localparam logic [OPC_W-1:0] OP_MUL   = 8'd4;
    localparam logic [OPC_W-1:0] OP_DIV   = 8'd5;
    localparam logic [OPC_W-1:0] OP_MOD   = 8'd6;
    localparam logic [OPC_W-1:0] OP_RDINT = 8'd7;
    localparam logic [OPC_W-1:0] OP_WRINT = 8'd8;
    localparam logic [OPC_W-1:0] OP_RDCHR = 8'd9;
    localparam logic [OPC_W-1:0] OP_WRCHR = 8'd10;
    localparam logic [OPC_W-1:0] OP_PUSHG = 8'd11;
    localparam logic [OPC_W-1:0] OP_POPG  = 8'd12;
    localparam logic [OPC_W-1:0] OP_ASF   = 8'd13;
    localparam logic [OPC_W-1:0] OP_RSF   = 8'd14;
    localparam logic [OPC_W-1:0] OP_PUSHL = 8'd15;
    localparam logic [OPC_W-1:0] OP_POPL  = 8'd16;
    localparam logic [OPC_W-1:0] OP_EQ    = 8'd17;
    localparam logic [OPC_W-1:0] OP_NE    = 8'd18;
    localparam logic [OPC_W-1:0] OP_LT    = 8'd19;
    localparam logic [OPC_W-1:0] OP_LE    = 8'd20;
    localparam logic [OPC_W-1:0] OP_GT    = 8'd21;
    localparam logic [OPC_W-1:0] OP_GE    = 8'd22;
    localparam logic [OPC_W-1:0] OP_JMP   = 8'd23;
    localparam logic [OPC_W-1:0] OP_BRF   = 8'd24;
    localparam logic [OPC_W-1:0] OP_BRT   = 8'd25;
    localparam logic [OPC_W-1:0] OP_CALL  = 8'd26;
    localparam logic [OPC_W-1:0] OP_RET   = 8'd27;
    localparam logic [OPC_W-1:0] OP_DROP  = 8'd28;
    localparam logic [OPC_W-1:0] OP_PUSHR = 8'd29;
    localparam logic [OPC_W-1:0] OP_POPR  = 8'd30;
    localparam logic [OPC_W-1:0] OP_DUP   = 8'd31;

    // error codes
    localparam logic [ERR_W-1:0] ERR_NONE      = 4'd0;
    localparam logic [ERR_W-1:0] ERR_UNDERFLOW = 4'd1;
    localparam logic [ERR_W-1:0] ERR_DIV_ZERO  = 4'd2;
    localparam logic [ERR_W-1:0] ERR_NEG_FRAME = 4'd3;
    localparam logic [ERR_W-1:0] ERR_NEG_LOCAL = 4'd4;
    localparam logic [ERR_W-1:0] ERR_CALL_RNG  = 4'd5;
    localparam logic [ERR_W-1:0] ERR_NEG_DROP  = 4'd6;
    localparam logic [ERR_W-1:0] ERR_POPR_EMPTY = 4'd7;
    localparam logic [ERR_W-1:0] ERR_OVERFLOW  = 4'd8;
    localparam logic [ERR_W-1:0] ERR_GLOB_RNG  = 4'd9;

    // request to the iterative divider
    typedef struct packed {
        logic              start;
        logic              is_mod;
        logic [WORD_W-1:0] dividend;
        logic [WORD_W-1:0] divisor;
    } div_req_t;

endpackage

`default_nettype wire

/* src/sme_if.sv */
// sme_in_if / sme_out_if: valid-ready channels of the stack machine executor
// depends on sme_pkg for field widths
`default_nettype none

interface sme_in_if;
    logic                              valid;
    logic                              ready;
    logic [sme_pkg::WORD_W-1:0]        instr_word;
    logic signed [sme_pkg::WORD_W-1:0] read_value;

    modport source (output valid, output instr_word, output read_value, input ready);
    modport sink   (input valid, input instr_word, input read_value, output ready);
endinterface

interface sme_out_if;
    logic                              valid;
    logic                              ready;
    logic [sme_pkg::NPC_W-1:0]         next_pc;
    logic                              out_valid;
    logic signed [sme_pkg::WORD_W-1:0] out_value;
    logic                              out_is_char;
    logic                              halted;
    logic [sme_pkg::ERR_W-1:0]         error_code;

    modport source (output valid, output next_pc, output out_valid, output out_value,
                    output out_is_char, output halted, output error_code, input ready);
    modport sink   (input valid, input next_pc, input out_valid, input out_value,
                    input out_is_char, input halted, input error_code, output ready);
endinterface

`default_nettype wire

/* src/sme_div.sv */
// sme_div: radix-2 restoring signed divider, one quotient bit per cycle
// depends on sme_pkg (div_req_t, WORD_W)
`default_nettype none

module sme_div (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire sme_pkg::div_req_t          req,
    output logic                            done,
    output logic [sme_pkg::WORD_W-1:0]      result
);
    localparam int W   = sme_pkg::WORD_W;
    localparam int CNW = $clog2(W);

    logic           busy_reg;
    logic           done_reg;
    logic [CNW-1:0] cnt_reg;
    logic [W:0]     rem_reg;
    logic [W-1:0]   quo_reg;
    logic [W-1:0]   den_reg;
    logic           neg_q_reg;
    logic           neg_r_reg;
    logic           mod_reg;

    logic [W-1:0] a_mag;
    logic [W-1:0] b_mag;
    logic [W:0]   rem_sh;
    logic [W:0]   diff;
    logic         ge;

    assign a_mag  = req.dividend[W-1] ? (~req.dividend + W'(1)) : req.dividend;
    assign b_mag  = req.divisor[W-1] ? (~req.divisor + W'(1)) : req.divisor;
    assign rem_sh = {rem_reg[W-1:0], quo_reg[W-1]};
    assign diff   = rem_sh - {1'b0, den_reg};
    assign ge     = ~diff[W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + CNW'(1);
            if (cnt_reg == CNW'(W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg   <= '0;
            quo_reg   <= a_mag;
            den_reg   <= b_mag;
            neg_q_reg <= req.dividend[W-1] ^ req.divisor[W-1];
            neg_r_reg <= req.dividend[W-1];
            mod_reg   <= req.is_mod;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff : rem_sh;
            quo_reg <= {quo_reg[W-2:0], ge};
        end
    end

    // signs applied after the magnitude loop; most negative / -1 wraps
    always_comb
    begin
        if (mod_reg)
            result = neg_r_reg ? (~rem_reg[W-1:0] + W'(1)) : rem_reg[W-1:0];
        else
            result = neg_q_reg ? (~quo_reg + W'(1)) : quo_reg;
    end

    assign done = done_reg;

endmodule

`default_nettype wire

/* src/stack_machine_executor_core.sv */
// stack_machine_executor_core: top level of the stack machine executor
// depends on sme_pkg, sme_in_if / sme_out_if and sme_div
`default_nettype none

// usage
//   in_ch carries one instruction per transaction (instr_word, read_value);
//   out_ch returns exactly one result transaction per instruction, in order
//   code_size and global_count are written through cfg_we / cfg_index / cfg_data
//   while no instruction is in flight
// timing
//   an instruction is accepted in idle, the stack and globals memories are read
//   at that edge and the next cycle executes and writes back once the output
//   register is free; div and mod also wait on the bit-serial divider
//   the single memory read/modify/write turn sets the rate, no overlap needed
// reset
//   pc, stack and frame pointers, return value, frame count, stop flag and
//   error clear; stack and globals contents are undefined until written
// stall
//   a finished result sits in the output register; the next instruction is
//   still accepted, and its write back waits until the output register frees

module stack_machine_executor_core #(
    parameter int STACK_DEPTH  = 1024,
    parameter int GLOBAL_DEPTH = 256,
    parameter int PC_WIDTH     = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    sme_in_if.sink                                 in_ch,
    sme_out_if.source                              out_ch,
    input  wire logic                              cfg_we,
    input  wire logic [sme_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [sme_pkg::CFG_DATA_W-1:0]    cfg_data
);
    localparam int W    = sme_pkg::WORD_W;
    localparam int IW   = sme_pkg::IMM_W;
    localparam int AW   = $clog2(STACK_DEPTH);
    localparam int SPW  = $clog2(STACK_DEPTH + 1);
    localparam int GAW  = (GLOBAL_DEPTH > 1) ? $clog2(GLOBAL_DEPTH) : 1;
    localparam int CW   = ((SPW > IW) ? SPW : IW) + 2;

    typedef enum logic [1:0] {S_IDLE, S_EXEC, S_DIV} state_t;

    // control and architectural state
    state_t                       state_reg;
    logic [PC_WIDTH-1:0]          pc_reg;
    logic [SPW-1:0]               sp_reg;
    logic [SPW-1:0]               fp_reg;
    logic [W-1:0]                 rv_reg;
    logic [W-1:0]                 fc_reg;
    logic                         stop_reg;
    logic [sme_pkg::ERR_W-1:0]    err_reg;
    logic [sme_pkg::CODE_W-1:0]   code_size_reg;
    logic [sme_pkg::GCNT_W-1:0]   gcount_reg;
    logic                         o_valid_reg;

    // latched instruction
    logic [sme_pkg::OPC_W-1:0]    op_reg;
    logic [IW-1:0]                imm_reg;
    logic [W-1:0]                 rd_reg;

    // output payload
    logic [sme_pkg::NPC_W-1:0]    o_pc_reg;
    logic                         o_ov_reg;
    logic [W-1:0]                 o_val_reg;
    logic                         o_chr_reg;
    logic                         o_halt_reg;
    logic [sme_pkg::ERR_W-1:0]    o_err_reg;

    // memories and their registered read data
    logic [W-1:0] stack_mem [STACK_DEPTH];
    logic [W-1:0] glob_mem  [GLOBAL_DEPTH];
    logic [W-1:0] rda_reg;
    logic [W-1:0] rdb_reg;
    logic [W-1:0] rdg_reg;

    // accept side read addressing
    logic                      acc;
    logic [sme_pkg::OPC_W-1:0] in_op;
    logic signed [CW-1:0]      in_imm_x;
    logic signed [CW-1:0]      fp_x;
    logic signed [CW-1:0]      in_loc;
    logic [SPW-1:0]            sp_m1;
    logic [SPW-1:0]            sp_m2;
    logic [SPW-1:0]            fp_m1;
    logic [AW-1:0]             addr_a;
    logic [AW-1:0]             addr_b;

    assign acc         = in_ch.valid && in_ch.ready;
    assign in_ch.ready = (state_reg == S_IDLE);
    assign in_op       = in_ch.instr_word[W-1:IW];
    assign in_imm_x    = $signed({{(CW-IW){in_ch.instr_word[IW-1]}}, in_ch.instr_word[IW-1:0]});
    assign fp_x        = $signed(CW'(fp_reg));
    assign in_loc      = fp_x + in_imm_x;
    assign sp_m1       = sp_reg - SPW'(1);
    assign sp_m2       = sp_reg - SPW'(2);
    assign fp_m1       = fp_reg - SPW'(1);

    // port a: second operand from top, local slot or saved frame pointer
    always_comb
    begin
        if (in_op == sme_pkg::OP_PUSHL)
            addr_a = in_loc[AW-1:0];
        else if (in_op == sme_pkg::OP_RSF)
            addr_a = fp_m1[AW-1:0];
        else
            addr_a = sp_m2[AW-1:0];
    end
    assign addr_b = sp_m1[AW-1:0];

    // execute stage
    logic signed [CW-1:0]      imm_x;
    logic signed [CW-1:0]      sp_x;
    logic signed [CW-1:0]      loc_idx;
    logic signed [CW-1:0]      asf_top;
    logic signed [CW-1:0]      drop_rem;
    logic signed [CW-1:0]      gl_x;
    logic [PC_WIDTH-1:0]       npc;
    logic [PC_WIDTH-1:0]       imm_pc;
    logic                      full;
    logic                      g_ok;
    logic [W-1:0]              div_res;
    logic                      div_done;
    sme_pkg::div_req_t         div_req;

    logic [sme_pkg::ERR_W-1:0] e;
    logic [SPW-1:0]            sp_n;
    logic [SPW-1:0]            fp_n;
    logic [PC_WIDTH-1:0]       pc_n;
    logic [W-1:0]              rv_n;
    logic [W-1:0]              fc_n;
    logic                      stop_n;
    logic [sme_pkg::ERR_W-1:0] err_n;
    logic                      swe;
    logic [AW-1:0]             swa;
    logic [W-1:0]              swd;
    logic                      gwe;
    logic                      ov;
    logic [W-1:0]              oval;
    logic                      ochr;
    logic                      need_div;
    logic                      slot_ok;
    logic                      commit;

    assign imm_x    = $signed({{(CW-IW){imm_reg[IW-1]}}, imm_reg});
    assign sp_x     = $signed(CW'(sp_reg));
    assign loc_idx  = fp_x + imm_x;
    assign asf_top  = sp_x + CW'(1) + imm_x;
    assign drop_rem = sp_x - imm_x;
    assign gl_x     = (gcount_reg < sme_pkg::GCNT_W'(GLOBAL_DEPTH > 511 ? 511 : GLOBAL_DEPTH)
                       || GLOBAL_DEPTH > 511) ?
                      $signed(CW'(gcount_reg)) : $signed(CW'(GLOBAL_DEPTH));
    assign npc      = pc_reg + PC_WIDTH'(1);
    assign imm_pc   = imm_x[PC_WIDTH-1:0];
    assign full     = (sp_reg >= SPW'(STACK_DEPTH));
    assign g_ok     = !imm_reg[IW-1] && (imm_x < gl_x);

    always_comb
    begin
        e        = sme_pkg::ERR_NONE;
        sp_n     = sp_reg;
        fp_n     = fp_reg;
        pc_n     = npc;
        rv_n     = rv_reg;
        fc_n     = fc_reg;
        stop_n   = stop_reg;
        swe      = 1'b0;
        swa      = sp_reg[AW-1:0];
        swd      = '0;
        gwe      = 1'b0;
        ov       = 1'b0;
        oval     = '0;
        ochr     = 1'b0;
        need_div = 1'b0;
        if (stop_reg)
        begin
            pc_n = pc_reg;
        end
        else
        begin
            case (op_reg)
                sme_pkg::OP_HALT:
                begin
                    stop_n = 1'b1;
                end
                sme_pkg::OP_PUSHC, sme_pkg::OP_RDINT, sme_pkg::OP_RDCHR,
                sme_pkg::OP_PUSHR:
                begin
                    if (full)
                        e = sme_pkg::ERR_OVERFLOW;
                    else
                    begin
                        swe  = 1'b1;
                        sp_n = sp_reg + SPW'(1);
                        if (op_reg == sme_pkg::OP_PUSHC)
                            swd = W'(imm_x);
                        else if (op_reg == sme_pkg::OP_RDINT)
                            swd = rd_reg;
                        else if (op_reg == sme_pkg::OP_RDCHR)
                            swd = {24'd0, rd_reg[7:0]};
                        else
                            swd = rv_reg;
                    end
                end
                sme_pkg::OP_ADD, sme_pkg::OP_SUB, sme_pkg::OP_MUL, sme_pkg::OP_DIV,
                sme_pkg::OP_MOD, sme_pkg::OP_EQ, sme_pkg::OP_NE, sme_pkg::OP_LT,
                sme_pkg::OP_LE, sme_pkg::OP_GT, sme_pkg::OP_GE:
                begin
                    if (sp_reg < SPW'(2))
                        e = sme_pkg::ERR_UNDERFLOW;
                    else if ((op_reg == sme_pkg::OP_DIV || op_reg == sme_pkg::OP_MOD)
                             && rdb_reg == '0)
                        e = sme_pkg::ERR_DIV_ZERO;
                    else
                    begin
                        swe  = 1'b1;
                        swa  = sp_m2[AW-1:0];
                        sp_n = sp_m1;
                        case (op_reg)
                            sme_pkg::OP_ADD: swd = rda_reg + rdb_reg;
                            sme_pkg::OP_SUB: swd = rda_reg - rdb_reg;
                            sme_pkg::OP_MUL: swd = rda_reg * rdb_reg;
                            sme_pkg::OP_EQ:  swd = W'(rda_reg == rdb_reg);
                            sme_pkg::OP_NE:  swd = W'(rda_reg != rdb_reg);
                            sme_pkg::OP_LT:  swd = W'($signed(rda_reg) < $signed(rdb_reg));
                            sme_pkg::OP_LE:  swd = W'($signed(rda_reg) <= $signed(rdb_reg));
                            sme_pkg::OP_GT:  swd = W'($signed(rda_reg) > $signed(rdb_reg));
                            sme_pkg::OP_GE:  swd = W'($signed(rda_reg) >= $signed(rdb_reg));
                            default:
                            begin
                                need_div = 1'b1;
                                swd      = div_res;
                            end
                        endcase
                    end
                end
                sme_pkg::OP_WRINT, sme_pkg::OP_WRCHR:
                begin
                    if (sp_reg == '0)
                        e = sme_pkg::ERR_UNDERFLOW;
                    else
                    begin
                        ov   = 1'b1;
                        ochr = (op_reg == sme_pkg::OP_WRCHR);
                        oval = ochr ? {24'd0, rdb_reg[7:0]} : rdb_reg;
                        sp_n = sp_m1;
                    end
                end
                sme_pkg::OP_PUSHG:
                begin
                    if (!g_ok)
                        e = sme_pkg::ERR_GLOB_RNG;
                    else if (full)
                        e = sme_pkg::ERR_OVERFLOW;
                    else
                    begin
                        swe  = 1'b1;
                        swd  = rdg_reg;
                        sp_n = sp_reg + SPW'(1);
                    end
                end
                sme_pkg::OP_POPG:
                begin
                    if (sp_reg == '0)
                        e = sme_pkg::ERR_UNDERFLOW;
                    else if (!g_ok)
                        e = sme_pkg::ERR_GLOB_RNG;
                    else
                    begin
                        gwe  = 1'b1;
                        sp_n = sp_m1;
                    end
                end
                sme_pkg::OP_ASF:
                begin
                    if (imm_reg[IW-1])
                        e = sme_pkg::ERR_NEG_FRAME;
                    else if (asf_top > $signed(CW'(STACK_DEPTH)))
                        e = sme_pkg::ERR_OVERFLOW;
                    else
                    begin
                        swe  = 1'b1;
                        swd  = W'(fp_reg);
                        fp_n = sp_reg + SPW'(1);
                        sp_n = asf_top[SPW-1:0];
                        fc_n = fc_reg + W'(1);
                    end
                end
                sme_pkg::OP_RSF:
                begin
                    if (fc_reg == '0)
                        e = sme_pkg::ERR_NEG_FRAME;
                    else if (fp_reg == '0 || fp_reg > SPW'(STACK_DEPTH))
                        e = sme_pkg::ERR_UNDERFLOW;
                    else if (rda_reg[W-1] || rda_reg > W'(STACK_DEPTH))
                        e = sme_pkg::ERR_OVERFLOW;
                    else
                    begin
                        sp_n = fp_m1;
                        fp_n = rda_reg[SPW-1:0];
                        fc_n = fc_reg - W'(1);
                    end
                end
                sme_pkg::OP_PUSHL, sme_pkg::OP_POPL:
                begin
                    if (op_reg == sme_pkg::OP_POPL && sp_reg == '0)
                        e = sme_pkg::ERR_UNDERFLOW;
                    else if (loc_idx < 0)
                        e = sme_pkg::ERR_NEG_LOCAL;
                    else if (loc_idx >= $signed(CW'(STACK_DEPTH)))
                        e = sme_pkg::ERR_OVERFLOW;
                    else if (op_reg == sme_pkg::OP_PUSHL)
                    begin
                        if (full)
                            e = sme_pkg::ERR_OVERFLOW;
                        else
                        begin
                            swe  = 1'b1;
                            swd  = rda_reg;
                            sp_n = sp_reg + SPW'(1);
                        end
                    end
                    else
                    begin
                        swe  = 1'b1;
                        swa  = loc_idx[AW-1:0];
                        swd  = rdb_reg;
                        sp_n = sp_m1;
                    end
                end
                sme_pkg::OP_JMP:
                begin
                    pc_n = imm_pc;
                end
                sme_pkg::OP_BRF, sme_pkg::OP_BRT:
                begin
                    if (sp_reg == '0)
                        e = sme_pkg::ERR_UNDERFLOW;
                    else
                    begin
                        sp_n = sp_m1;
                        if ((op_reg == sme_pkg::OP_BRF && rdb_reg == W'(0)) ||
                            (op_reg == sme_pkg::OP_BRT && rdb_reg == W'(1)))
                            pc_n = imm_pc;
                    end
                end
                sme_pkg::OP_CALL:
                begin
                    if (imm_reg[IW-1] || imm_x > $signed(CW'(code_size_reg)))
                        e = sme_pkg::ERR_CALL_RNG;
                    else if (full)
                        e = sme_pkg::ERR_OVERFLOW;
                    else
                    begin
                        swe  = 1'b1;
                        swd  = W'(npc);
                        sp_n = sp_reg + SPW'(1);
                        pc_n = imm_pc;
                    end
                end
                sme_pkg::OP_RET:
                begin
                    if (sp_reg == '0)
                        e = sme_pkg::ERR_UNDERFLOW;
                    else
                    begin
                        pc_n = rdb_reg[PC_WIDTH-1:0];
                        sp_n = sp_m1;
                    end
                end
                sme_pkg::OP_DROP:
                begin
                    if (imm_reg[IW-1])
                        e = sme_pkg::ERR_NEG_DROP;
                    else if (imm_x > sp_x)
                        e = sme_pkg::ERR_UNDERFLOW;
                    else
                        sp_n = drop_rem[SPW-1:0];
                end
                sme_pkg::OP_POPR:
                begin
                    if (sp_reg == '0)
                        e = sme_pkg::ERR_POPR_EMPTY;
                    else
                    begin
                        rv_n = rdb_reg;
                        sp_n = sp_m1;
                    end
                end
                sme_pkg::OP_DUP:
                begin
                    if (sp_reg == '0)
                        e = sme_pkg::ERR_UNDERFLOW;
                    else if (full)
                        e = sme_pkg::ERR_OVERFLOW;
                    else
                    begin
                        swe  = 1'b1;
                        swd  = rdb_reg;
                        sp_n = sp_reg + SPW'(1);
                    end
                end
                default:
                begin
                    // undefined opcodes only advance the pc
                end
            endcase
            // a fault leaves everything but the stop flag and error code
            if (e != sme_pkg::ERR_NONE)
            begin
                sp_n     = sp_reg;
                fp_n     = fp_reg;
                pc_n     = pc_reg;
                rv_n     = rv_reg;
                fc_n     = fc_reg;
                stop_n   = 1'b1;
                swe      = 1'b0;
                gwe      = 1'b0;
                ov       = 1'b0;
                oval     = '0;
                ochr     = 1'b0;
                need_div = 1'b0;
            end
        end
        err_n = (e != sme_pkg::ERR_NONE) ? e : err_reg;
    end

    // write back waits for a free output register
    assign slot_ok = !o_valid_reg || out_ch.ready;
    assign commit  = slot_ok && (((state_reg == S_EXEC) && !need_div) ||
                                 ((state_reg == S_DIV) && div_done));

    assign div_req.start    = (state_reg == S_EXEC) && need_div;
    assign div_req.is_mod   = (op_reg == sme_pkg::OP_MOD);
    assign div_req.dividend = rda_reg;
    assign div_req.divisor  = rdb_reg;

    sme_div u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (div_req),
        .done   (div_done),
        .result (div_res)
    );

    // memories: read at accept, write at commit; never on the same edge
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            rda_reg <= stack_mem[addr_a];
            rdb_reg <= stack_mem[addr_b];
            rdg_reg <= glob_mem[in_ch.instr_word[GAW-1:0]];
        end
        if (commit && swe)
            stack_mem[swa] <= swd;
        if (commit && gwe)
            glob_mem[imm_reg[GAW-1:0]] <= rdb_reg;
    end

    // state, architectural registers and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pc_reg        <= '0;
            sp_reg        <= '0;
            fp_reg        <= '0;
            rv_reg        <= '0;
            fc_reg        <= '0;
            stop_reg      <= 1'b0;
            err_reg       <= sme_pkg::ERR_NONE;
            code_size_reg <= '0;
            gcount_reg    <= '0;
            o_valid_reg   <= 1'b0;
            op_reg        <= '0;
            imm_reg       <= '0;
            rd_reg        <= '0;
            o_pc_reg      <= '0;
            o_ov_reg      <= 1'b0;
            o_val_reg     <= '0;
            o_chr_reg     <= 1'b0;
            o_halt_reg    <= 1'b0;
            o_err_reg     <= sme_pkg::ERR_NONE;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    sme_pkg::CFG_CODE_SIZE:    code_size_reg <= cfg_data;
                    sme_pkg::CFG_GLOBAL_COUNT: gcount_reg <= cfg_data[sme_pkg::GCNT_W-1:0];
                    default:                   code_size_reg <= code_size_reg;
                endcase
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (acc)
                    begin
                        op_reg    <= in_op;
                        imm_reg   <= in_ch.instr_word[IW-1:0];
                        rd_reg    <= in_ch.read_value;
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    if (need_div)
                        state_reg <= S_DIV;
                    else if (commit)
                        state_reg <= S_IDLE;
                end
                S_DIV:
                begin
                    if (commit)
                        state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
            if (commit)
            begin
                pc_reg      <= pc_n;
                sp_reg      <= sp_n;
                fp_reg      <= fp_n;
                rv_reg      <= rv_n;
                fc_reg      <= fc_n;
                stop_reg    <= stop_n;
                err_reg     <= err_n;
                o_valid_reg <= 1'b1;
                o_pc_reg    <= sme_pkg::NPC_W'(pc_n);
                o_ov_reg    <= ov;
                o_val_reg   <= oval;
                o_chr_reg   <= ochr;
                o_halt_reg  <= stop_n;
                o_err_reg   <= err_n;
            end
            else if (out_ch.ready)
            begin
                o_valid_reg <= 1'b0;
            end
        end
    end

    assign out_ch.valid       = o_valid_reg;
    assign out_ch.next_pc     = o_pc_reg;
    assign out_ch.out_valid   = o_ov_reg;
    assign out_ch.out_value   = o_val_reg;
    assign out_ch.out_is_char = o_chr_reg;
    assign out_ch.halted      = o_halt_reg;
    assign out_ch.error_code  = o_err_reg;

    // one instruction in flight at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        acc |=> !in_ch.ready)
        else $error("instruction accepted while another is in flight");

    // a recorded fault always stops the machine
    a_err_stops: assert property (@(posedge clk) disable iff (!rst_n)
        (err_reg != sme_pkg::ERR_NONE) |-> stop_reg)
        else $error("error code set without stop flag");

    // pointers stay within the stack
    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        (sp_reg <= SPW'(STACK_DEPTH)) && (fp_reg <= SPW'(STACK_DEPTH)))
        else $error("stack or frame pointer beyond stack depth");

    // the divider is waited on only for div and mod
    a_div_op: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (op_reg == sme_pkg::OP_DIV || op_reg == sme_pkg::OP_MOD))
        else $error("divider wait for a non-division opcode");

endmodule

`default_nettype wire

/* bench/stack_machine_executor_core_test.sv */
// stack_machine_executor_core_test: self-checking bench of the stack machine executor
// drives instructions on sme_in_if, checks results on sme_out_if against a local predictor
// depends on sme_pkg, sme_if.sv and the stack_machine_executor_core rtl
`default_nettype none

module stack_machine_executor_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STK_DEPTH   = 1024;
    localparam int GLB_DEPTH   = 256;
    localparam int PC_MASK     = 16'hFFFF;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_WAIT  = 40;      // covers the bit-serial divider
    localparam int RANDOM_ITEMS = 240;    // per idling phase
    localparam int N_DIRECTED  = 27;

    typedef struct packed {
        logic [sme_pkg::NPC_W-1:0]  npc;
        logic                       ov;
        logic [sme_pkg::WORD_W-1:0] oval;
        logic                       ochr;
        logic                       halted;
        logic [sme_pkg::ERR_W-1:0]  err;
    } exec_result_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [sme_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [sme_pkg::CFG_DATA_W-1:0] cfg_data;

    sme_in_if  in_if ();
    sme_out_if out_if ();

    stack_machine_executor_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_if),
        .out_ch    (out_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // machine state as predicted
    int unsigned pc_q, sp_q, fp_q, frames_q;
    logic [31:0] retval_q;
    bit          stopped_q;
    logic [3:0]  err_q;
    logic [31:0] stack_mem [STK_DEPTH];
    bit          stack_set [STK_DEPTH];
    logic [31:0] glob_mem [GLB_DEPTH];
    bit          glob_set [GLB_DEPTH];
    int unsigned code_size_q, glob_count_q;

    exec_result_t pending_results[$];
    int  mismatches;
    int  n_checked;
    int  n_writes;
    int  cycles;
    int  src_idle;
    int  sink_idle;

    // directed stimulus table
    logic [31:0] dir_word [0:N_DIRECTED-1] = '{
        {sme_pkg::OP_PUSHC, 24'h7FFFFF}, {sme_pkg::OP_PUSHC, 24'h800000},
        {sme_pkg::OP_ADD, 24'h0},        {sme_pkg::OP_RDINT, 24'h0},
        {sme_pkg::OP_PUSHC, 24'hFFFFFF}, {sme_pkg::OP_DIV, 24'h0},
        {sme_pkg::OP_PUSHC, 24'hFFFFFF}, {sme_pkg::OP_MOD, 24'h0},
        {sme_pkg::OP_WRINT, 24'h0},      {sme_pkg::OP_RDCHR, 24'h0},
        {sme_pkg::OP_WRCHR, 24'h0},      {sme_pkg::OP_POPG, 24'd255},
        {sme_pkg::OP_PUSHG, 24'd255},    {sme_pkg::OP_ASF, 24'd2},
        {sme_pkg::OP_PUSHC, 24'd7},      {sme_pkg::OP_POPL, 24'd1},
        {sme_pkg::OP_PUSHL, 24'd1},      {sme_pkg::OP_PUSHL, 24'hFFFFFF},
        {sme_pkg::OP_LT, 24'h0},         {sme_pkg::OP_POPR, 24'h0},
        {sme_pkg::OP_PUSHR, 24'h0},      {sme_pkg::OP_BRT, 24'h10},
        {sme_pkg::OP_CALL, 24'd3},       {sme_pkg::OP_RET, 24'h0},
        {sme_pkg::OP_DROP, 24'd1},       {sme_pkg::OP_RSF, 24'h0},
        {8'hFF, 24'hFFFFFF}
    };
    logic [31:0] dir_rd [0:N_DIRECTED-1] = '{
        32'h0, 32'h0, 32'h0, 32'h80000000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
        32'h000001FF, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
        32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'hFFFFFFFF
    };
    exec_result_t dir_exp   [0:N_DIRECTED-1];
    bit           dir_typed [0:N_DIRECTED-1];

    function automatic logic [31:0] stack_read(int unsigned i, inout bit unwritten);
        if (!stack_set[i])
            unwritten = 1'b1;
        return stack_mem[i];
    endfunction

    function automatic void stack_write(int unsigned i, logic [31:0] v, bit commit);
        if (commit)
        begin
            stack_mem[i] = v;
            stack_set[i] = 1'b1;
        end
    endfunction

    // executes one instruction; with commit clear nothing changes and only the
    // result and the read-of-unwritten flag come back
    function automatic void execute_instr(input logic [31:0] w, input logic [31:0] rd,
                                          input bit commit, output exec_result_t r,
                                          output bit unwritten);
        logic [7:0]  op;
        longint      imm;
        int unsigned npc, s, gl, n_sp, n_fp, n_fc;
        logic [31:0] a, b, v, n_rv;
        logic [3:0]  e;
        logic        ov, ochr, n_stop;
        logic [31:0] oval;
        longint      sa, sb, idx;
        op = w[31:24];
        imm = longint'($signed(w[23:0]));
        npc = (pc_q + 1) & PC_MASK;
        s = sp_q;
        gl = (glob_count_q < GLB_DEPTH) ? glob_count_q : GLB_DEPTH;
        n_sp = sp_q; n_fp = fp_q; n_fc = frames_q; n_rv = retval_q; n_stop = stopped_q;
        e = sme_pkg::ERR_NONE; ov = 1'b0; ochr = 1'b0; oval = '0;
        unwritten = 1'b0;
        if (!stopped_q)
        begin
            case (op)
                sme_pkg::OP_HALT: n_stop = 1'b1;
                sme_pkg::OP_PUSHC, sme_pkg::OP_RDINT, sme_pkg::OP_RDCHR, sme_pkg::OP_PUSHR:
                begin
                    if (s >= STK_DEPTH)
                        e = sme_pkg::ERR_OVERFLOW;
                    else
                    begin
                        v = (op == sme_pkg::OP_PUSHC) ? imm[31:0] :
                            (op == sme_pkg::OP_RDINT) ? rd :
                            (op == sme_pkg::OP_RDCHR) ? {24'b0, rd[7:0]} : retval_q;
                        stack_write(s, v, commit);
                        n_sp = s + 1;
                    end
                end
                sme_pkg::OP_ADD, sme_pkg::OP_SUB, sme_pkg::OP_MUL, sme_pkg::OP_DIV,
                sme_pkg::OP_MOD:
                begin
                    if (s < 2)
                        e = sme_pkg::ERR_UNDERFLOW;
                    else
                    begin
                        a = stack_read(s - 2, unwritten);
                        b = stack_read(s - 1, unwritten);
                        sa = longint'($signed(a));
                        sb = longint'($signed(b));
                        if ((op == sme_pkg::OP_DIV || op == sme_pkg::OP_MOD) && b == 0)
                            e = sme_pkg::ERR_DIV_ZERO;
                        else
                        begin
                            // 64-bit signed math truncates toward zero; int_min / -1 wraps on the cut
                            case (op)
                                sme_pkg::OP_ADD: v = a + b;
                                sme_pkg::OP_SUB: v = a - b;
                                sme_pkg::OP_MUL: v = a * b;
                                sme_pkg::OP_DIV: v = 32'(sa / sb);
                                default:         v = 32'(sa % sb);
                            endcase
                            stack_write(s - 2, v, commit);
                            n_sp = s - 1;
                        end
                    end
                end
                sme_pkg::OP_WRINT, sme_pkg::OP_WRCHR:
                begin
                    if (s < 1)
                        e = sme_pkg::ERR_UNDERFLOW;
                    else
                    begin
                        a = stack_read(s - 1, unwritten);
                        ov = 1'b1;
                        ochr = (op == sme_pkg::OP_WRCHR);
                        oval = ochr ? {24'b0, a[7:0]} : a;
                        n_sp = s - 1;
                    end
                end
                sme_pkg::OP_PUSHG:
                begin
                    if (imm < 0 || imm >= longint'(gl))
                        e = sme_pkg::ERR_GLOB_RNG;
                    else if (s >= STK_DEPTH)
                        e = sme_pkg::ERR_OVERFLOW;
                    else
                    begin
                        if (!glob_set[imm])
                            unwritten = 1'b1;
                        stack_write(s, glob_mem[imm], commit);
                        n_sp = s + 1;
                    end
                end
                sme_pkg::OP_POPG:
                begin
                    if (s < 1)
                        e = sme_pkg::ERR_UNDERFLOW;
                    else if (imm < 0 || imm >= longint'(gl))
                        e = sme_pkg::ERR_GLOB_RNG;
                    else
                    begin
                        v = stack_read(s - 1, unwritten);
                        if (commit)
                        begin
                            glob_mem[imm] = v;
                            glob_set[imm] = 1'b1;
                        end
                        n_sp = s - 1;
                    end
                end
                sme_pkg::OP_ASF:
                begin
                    if (imm < 0)
                        e = sme_pkg::ERR_NEG_FRAME;
                    else if (longint'(s) + 1 + imm > STK_DEPTH)
                        e = sme_pkg::ERR_OVERFLOW;
                    else
                    begin
                        stack_write(s, fp_q, commit);
                        n_fp = s + 1;
                        n_sp = s + 1 + int'(imm);
                        n_fc = frames_q + 1;
                    end
                end
                sme_pkg::OP_RSF:
                begin
                    if (frames_q == 0)
                        e = sme_pkg::ERR_NEG_FRAME;
                    else if (fp_q < 1 || fp_q > STK_DEPTH)
                        e = sme_pkg::ERR_UNDERFLOW;
                    else
                    begin
                        sa = longint'($signed(stack_read(fp_q - 1, unwritten)));
                        if (sa < 0 || sa > STK_DEPTH)
                            e = sme_pkg::ERR_OVERFLOW;
                        else
                        begin
                            n_sp = fp_q - 1;
                            n_fp = int'(sa);
                            n_fc = frames_q - 1;
                        end
                    end
                end
                sme_pkg::OP_PUSHL, sme_pkg::OP_POPL:
                begin
                    idx = longint'(fp_q) + imm;
                    if (op == sme_pkg::OP_POPL && s < 1)
                        e = sme_pkg::ERR_UNDERFLOW;
                    else if (idx < 0)
                        e = sme_pkg::ERR_NEG_LOCAL;
                    else if (idx >= STK_DEPTH)
                        e = sme_pkg::ERR_OVERFLOW;
                    else if (op == sme_pkg::OP_PUSHL)
                    begin
                        if (s >= STK_DEPTH)
                            e = sme_pkg::ERR_OVERFLOW;
                        else
                        begin
                            v = stack_read(idx, unwritten);
                            stack_write(s, v, commit);
                            n_sp = s + 1;
                        end
                    end
                    else
                    begin
                        v = stack_read(s - 1, unwritten);
                        stack_write(idx, v, commit);
                        n_sp = s - 1;
                    end
                end
                sme_pkg::OP_EQ, sme_pkg::OP_NE, sme_pkg::OP_LT, sme_pkg::OP_LE,
                sme_pkg::OP_GT, sme_pkg::OP_GE:
                begin
                    if (s < 2)
                        e = sme_pkg::ERR_UNDERFLOW;
                    else
                    begin
                        sa = longint'($signed(stack_read(s - 2, unwritten)));
                        sb = longint'($signed(stack_read(s - 1, unwritten)));
                        case (op)
                            sme_pkg::OP_EQ: v = 32'(sa == sb);
                            sme_pkg::OP_NE: v = 32'(sa != sb);
                            sme_pkg::OP_LT: v = 32'(sa < sb);
                            sme_pkg::OP_LE: v = 32'(sa <= sb);
                            sme_pkg::OP_GT: v = 32'(sa > sb);
                            default:        v = 32'(sa >= sb);
                        endcase
                        stack_write(s - 2, v, commit);
                        n_sp = s - 1;
                    end
                end
                sme_pkg::OP_JMP: npc = int'(imm) & PC_MASK;
                sme_pkg::OP_BRF, sme_pkg::OP_BRT:
                begin
                    if (s < 1)
                        e = sme_pkg::ERR_UNDERFLOW;
                    else
                    begin
                        a = stack_read(s - 1, unwritten);
                        // brt only takes an exact 1
                        if ((op == sme_pkg::OP_BRF && a == 0) ||
                            (op == sme_pkg::OP_BRT && a == 1))
                            npc = int'(imm) & PC_MASK;
                        n_sp = s - 1;
                    end
                end
                sme_pkg::OP_CALL:
                begin
                    if (imm < 0 || imm > longint'(code_size_q))
                        e = sme_pkg::ERR_CALL_RNG;
                    else if (s >= STK_DEPTH)
                        e = sme_pkg::ERR_OVERFLOW;
                    else
                    begin
                        stack_write(s, npc, commit);
                        n_sp = s + 1;
                        npc = int'(imm) & PC_MASK;
                    end
                end
                sme_pkg::OP_RET:
                begin
                    if (s < 1)
                        e = sme_pkg::ERR_UNDERFLOW;
                    else
                    begin
                        npc = stack_read(s - 1, unwritten) & PC_MASK;
                        n_sp = s - 1;
                    end
                end
                sme_pkg::OP_DROP:
                begin
                    if (imm < 0)
                        e = sme_pkg::ERR_NEG_DROP;
                    else if (imm > longint'(s))
                        e = sme_pkg::ERR_UNDERFLOW;
                    else
                        n_sp = s - int'(imm);
                end
                sme_pkg::OP_POPR:
                begin
                    if (s < 1)
                        e = sme_pkg::ERR_POPR_EMPTY;
                    else
                    begin
                        n_rv = stack_read(s - 1, unwritten);
                        n_sp = s - 1;
                    end
                end
                sme_pkg::OP_DUP:
                begin
                    if (s < 1)
                        e = sme_pkg::ERR_UNDERFLOW;
                    else if (s >= STK_DEPTH)
                        e = sme_pkg::ERR_OVERFLOW;
                    else
                    begin
                        v = stack_read(s - 1, unwritten);
                        stack_write(s, v, commit);
                        n_sp = s + 1;
                    end
                end
                default: ;  // unknown opcodes only advance the counter
            endcase
        end
        // a fault leaves everything but the stop flag and error code alone
        r.npc = (stopped_q || e != sme_pkg::ERR_NONE) ? pc_q[15:0] : npc[15:0];
        r.ov = (e == sme_pkg::ERR_NONE) ? ov : 1'b0;
        r.oval = (e == sme_pkg::ERR_NONE) ? oval : '0;
        r.ochr = (e == sme_pkg::ERR_NONE) ? ochr : 1'b0;
        r.halted = (e != sme_pkg::ERR_NONE) ? 1'b1 : n_stop;
        r.err = (e != sme_pkg::ERR_NONE) ? e : err_q;
        if (commit && !stopped_q)
        begin
            if (e != sme_pkg::ERR_NONE)
            begin
                stopped_q = 1'b1;
                err_q = e;
            end
            else
            begin
                pc_q = npc; sp_q = n_sp; fp_q = n_fp; frames_q = n_fc;
                retval_q = n_rv; stopped_q = n_stop;
            end
        end
    endfunction

    // picks an instruction that keeps the machine running and reads only written entries
    function automatic void pick_instr(output logic [31:0] w, output logic [31:0] rd);
        logic [7:0]   op;
        logic [23:0]  imm;
        exec_result_t r;
        bit           unwritten;
        int           gl, lim;
        for (int tries = 0; tries < 40; tries++)
        begin
            imm = 24'($urandom);
            rd = $urandom;
            if ($urandom_range(99) < 3)
                op = 8'($urandom_range(32, 255));
            else if (sp_q < 3 && $urandom_range(1) == 1)
                op = sme_pkg::OP_PUSHC;
            else
                op = 8'($urandom_range(1, 31));
            gl = (glob_count_q < GLB_DEPTH) ? glob_count_q : GLB_DEPTH;
            lim = (sp_q < 3) ? sp_q : 3;
            case (op)
                sme_pkg::OP_PUSHG, sme_pkg::OP_POPG:
                    imm = (gl > 0) ? 24'($urandom_range(0, gl - 1)) : 24'h0;
                sme_pkg::OP_ASF:  imm = 24'($urandom_range(0, 3));
                sme_pkg::OP_CALL: imm = 24'($urandom_range(0, code_size_q));
                sme_pkg::OP_DROP: imm = 24'($urandom_range(0, lim));
                sme_pkg::OP_PUSHL, sme_pkg::OP_POPL:
                    if (sp_q > 0)
                        imm = 24'(int'($urandom_range(0, sp_q - 1)) - int'(fp_q));
                default: ;
            endcase
            w = {op, imm};
            execute_instr(w, rd, 1'b0, r, unwritten);
            if (!unwritten && !r.halted)
                return;
        end
        // fallback: a plain push, or a single drop at a full stack
        w = (sp_q < STK_DEPTH) ? {sme_pkg::OP_PUSHC, 24'($urandom)} :
                                 {sme_pkg::OP_DROP, 24'd1};
    endfunction

    // clock and cycle watchdog
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // result side: random back-pressure at each edge
    initial
    begin
        out_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            out_if.ready <= ($urandom_range(99) >= sink_idle);
        end
    end

    // result checker: sampled mid-cycle, where every signal is settled
    initial
    begin
        exec_result_t exp;
        forever
        begin
            @(negedge clk);
            if (rst_n && out_if.valid && out_if.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result transaction with nothing expected");
                    mismatches++;
                end
                else
                begin
                    exp = pending_results.pop_front();
                    n_checked++;
                    if (out_if.next_pc !== exp.npc)
                    begin
                        $error("next_pc: expected %0d, got %0d", exp.npc, out_if.next_pc);
                        mismatches++;
                    end
                    if (out_if.out_valid !== exp.ov)
                    begin
                        $error("out_valid: expected %0d, got %0d", exp.ov, out_if.out_valid);
                        mismatches++;
                    end
                    if (out_if.out_value !== exp.oval)
                    begin
                        $error("out_value: expected %0h, got %0h", exp.oval, out_if.out_value);
                        mismatches++;
                    end
                    if (out_if.out_is_char !== exp.ochr)
                    begin
                        $error("out_is_char: expected %0d, got %0d", exp.ochr,
                               out_if.out_is_char);
                        mismatches++;
                    end
                    if (out_if.halted !== exp.halted)
                    begin
                        $error("halted: expected %0d, got %0d", exp.halted, out_if.halted);
                        mismatches++;
                    end
                    if (out_if.error_code !== exp.err)
                    begin
                        $error("error_code: expected %0d, got %0d", exp.err,
                               out_if.error_code);
                        mismatches++;
                    end
                end
            end
        end
    end

    // sends one instruction transaction and queues its expected result;
    // starts and ends right after a rising edge
    task automatic issue(input logic [31:0] w, input logic [31:0] rd,
                         input bit typed, input exec_result_t typed_exp);
        exec_result_t r;
        bit           unwritten;
        bit           taken;
        while ($urandom_range(99) < src_idle)
        begin
            in_if.valid <= 1'b0;
            @(posedge clk);
        end
        in_if.valid <= 1'b1;
        in_if.instr_word <= w;
        in_if.read_value <= rd;
        do
        begin
            @(negedge clk);
            taken = in_if.ready;
            @(posedge clk);
        end
        while (!taken);
        execute_instr(w, rd, 1'b1, r, unwritten);
        if (r.ov)
            n_writes++;
        pending_results.push_back(typed ? typed_exp : r);
    endtask

    // waits out every expected result, lowering valid first
    task automatic drain();
        in_if.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // both registers back to back with the write enable held high
    task automatic set_config(input int unsigned code_size, input int unsigned glob_count);
        cfg_we <= 1'b1;
        cfg_index <= sme_pkg::CFG_CODE_SIZE;
        cfg_data <= sme_pkg::CFG_DATA_W'(code_size);
        @(posedge clk);
        cfg_index <= sme_pkg::CFG_GLOBAL_COUNT;
        cfg_data <= sme_pkg::CFG_DATA_W'(glob_count);
        @(posedge clk);
        cfg_we <= 1'b0;
        code_size_q = code_size;
        glob_count_q = glob_count;
    endtask

    // main sequence
    initial
    begin
        logic [31:0]  w, rd;
        exec_result_t none;
        int           code_sizes [3];
        int           glob_counts [3];
        int           src_pct [3];
        int           sink_pct [3];
        code_sizes = '{65535, 0, 1000};
        glob_counts = '{256, 1, 0};
        src_pct = '{38, 48, 0};
        sink_pct = '{48, 38, 0};
        none = '0;
        cycles = 0; mismatches = 0; n_checked = 0; n_writes = 0;
        src_idle = 0; sink_idle = 0;
        pc_q = 0; sp_q = 0; fp_q = 0; frames_q = 0; retval_q = '0;
        stopped_q = 1'b0; err_q = sme_pkg::ERR_NONE; code_size_q = 0; glob_count_q = 0;
        for (int i = 0; i < STK_DEPTH; i++)
            stack_set[i] = 1'b0;
        for (int i = 0; i < GLB_DEPTH; i++)
            glob_set[i] = 1'b0;

        // hand-checked rows: first push after reset, and the two writes
        for (int i = 0; i < N_DIRECTED; i++)
        begin
            dir_exp[i] = '0;
            dir_typed[i] = 1'b0;
        end
        dir_typed[0] = 1'b1;  dir_exp[0].npc = 16'd1;
        dir_typed[8] = 1'b1;  dir_exp[8].npc = 16'd9;  dir_exp[8].ov = 1'b1;
        dir_typed[10] = 1'b1; dir_exp[10].npc = 16'd11; dir_exp[10].ov = 1'b1;
        dir_exp[10].oval = 32'hFF; dir_exp[10].ochr = 1'b1;

        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= sme_pkg::CFG_CODE_SIZE;
        cfg_data <= '0;
        in_if.valid <= 1'b0;
        in_if.instr_word <= '0;
        in_if.read_value <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part: limits of the immediate, int_min wrap on div and mod,
        // char truncation, globals, frames, locals, branches and calls
        set_config(65535, 256);
        for (int i = 0; i < N_DIRECTED; i++)
            issue(dir_word[i], dir_rd[i], dir_typed[i], dir_exp[i]);
        drain();

        // random phases, each under its own idling pattern and register setting
        for (int ph = 0; ph < 3; ph++)
        begin
            set_config(code_sizes[ph], glob_counts[ph]);
            src_idle = src_pct[ph];
            sink_idle = sink_pct[ph];
            for (int n = 0; n < RANDOM_ITEMS; n++)
            begin
                // one full stop of the sender mid-phase
                if (ph == 0 && n == RANDOM_ITEMS / 2)
                begin
                    in_if.valid <= 1'b0;
                    while (pending_results.size() != 0)
                        @(posedge clk);
                end
                pick_instr(w, rd);
                issue(w, rd, 1'b0, none);
            end
            drain();
        end

        // the machine stops for good here: a fault, then instructions it must ignore
        issue({sme_pkg::OP_PUSHC, 24'h0}, 32'h0, 1'b0, none);
        issue({sme_pkg::OP_PUSHC, 24'h0}, 32'h0, 1'b0, none);
        issue({sme_pkg::OP_DIV, 24'h0}, 32'h0, 1'b0, none);
        issue({sme_pkg::OP_PUSHC, 24'h1}, 32'h0, 1'b0, none);
        issue({sme_pkg::OP_HALT, 24'h0}, 32'h0, 1'b0, none);
        drain();

        $display("checked %0d results (%0d with output), %0d mismatching fields",
                 n_checked, n_writes, mismatches);
        $display("covered three idling patterns, register extremes and a final fault");
        if (mismatches == 0 && pending_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire

/* sim.f */
src/sme_pkg.sv
src/sme_if.sv
src/sme_div.sv
src/stack_machine_executor_core.sv
bench/stack_machine_executor_core_test.sv
